>>> sv/smn_pkg.sv
// Shared types, message codes and reply byte helpers of the SCSI message negotiator.
`default_nettype none
package smn_pkg;

	typedef enum logic [1:0] {
		KIND_BYTE     = 2'd0,
		KIND_COMPLETE = 2'd1,
		KIND_READ     = 2'd2,
		KIND_SESSION  = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LEAD,
		S_HEAD,
		S_LEN,
		S_CODE,
		S_PER,
		S_OFF,
		S_WIDTH,
		S_DONE
	} walk_state_t;

	typedef enum logic [1:0] {
		RK_NONE,
		RK_REJECT,
		RK_SYNC,
		RK_WIDE
	} reply_kind_t;

	localparam logic [7:0] EXT_MSG    = 8'h01;
	localparam logic [7:0] REJECT_MSG = 8'h07;
	localparam logic [7:0] CODE_SYNC  = 8'h01;
	localparam logic [7:0] CODE_WIDE  = 8'h03;
	localparam int         IDENT_BIT  = 7;
	localparam logic [7:0] SYNC_LEN   = 8'd3;
	localparam logic [7:0] WIDE_LEN   = 8'd2;

	localparam logic [7:0] MIN_PERIOD_RST   = 8'd25;
	localparam logic [7:0] MAX_OFFSET_RST   = 8'd8;
	localparam logic       WIDE_CAPABLE_RST = 1'b0;

	localparam logic [1:0] REG_MIN_PERIOD   = 2'd0;
	localparam logic [1:0] REG_MAX_OFFSET   = 2'd1;
	localparam logic [1:0] REG_WIDE_CAPABLE = 2'd2;

	typedef struct packed {
		logic        load;
		reply_kind_t kind;
		logic [7:0]  per;
		logic [7:0]  off;
		logic        wide;
	} reply_wr_t;

	typedef struct packed {
		logic pop;
		logic clear;
	} reply_ctl_t;

	function automatic logic [2:0] reply_len(input reply_kind_t kind);
		logic [2:0] len;
		case (kind)
			RK_REJECT: len = 3'd1;
			RK_SYNC:   len = 3'd5;
			RK_WIDE:   len = 3'd4;
			default:   len = 3'd0;
		endcase
		return len;
	endfunction

	function automatic logic [7:0] reply_byte(
		input reply_kind_t kind,
		input logic [2:0]  idx,
		input logic [7:0]  per,
		input logic [7:0]  off,
		input logic        wide
	);
		logic [7:0] b;
		b = 8'h00;
		case (kind)
			RK_REJECT: b = REJECT_MSG;
			RK_SYNC: begin
				case (idx)
					3'd0:    b = EXT_MSG;
					3'd1:    b = SYNC_LEN;
					3'd2:    b = CODE_SYNC;
					3'd3:    b = per;
					default: b = off;
				endcase
			end
			RK_WIDE: begin
				case (idx)
					3'd0:    b = EXT_MSG;
					3'd1:    b = WIDE_LEN;
					3'd2:    b = CODE_WIDE;
					default: b = {7'd0, wide};
				endcase
			end
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

>>> sv/scsi_message_negotiator_core.sv
// Top level: configuration, buffer walk sequencer and registered result word.
// Byte, read and session-reset words give their result in the cycle after acceptance.
// A complete word walks the buffer through the registered-read buffer memory, one
// message at a time through the lead, head, length, code and period/offset or width
// states, and loads the result word from the done state once the result register is free.
// Asynchronous reset sets the configuration registers to their defaults and empties both queues.
`default_nettype none
module scsi_message_negotiator_core #(
	parameter int MSG_DEPTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
	input  wire logic [1:0]  s_tuser,   // [1:0] kind
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [0] ok, [8:1] reply_byte, [9] saw_identify, [10] saw_reject, [11] did_sync,
	// [12] did_wide, [13] incomplete, [21:14] agreed_period, [29:22] agreed_offset,
	// [30] agreed_wide, [31] zero
	output logic [31:0]      m_tdata,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data
);

	localparam int CW = $clog2(MSG_DEPTH + 1);
	localparam int AW = $clog2(MSG_DEPTH);
	localparam int SW = ((CW > 8) ? CW : 8) + 2;

	// configuration
	logic [7:0] min_period_q;
	logic [7:0] max_offset_q;
	logic       wide_capable_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_period_q   <= smn_pkg::MIN_PERIOD_RST;
			max_offset_q   <= smn_pkg::MAX_OFFSET_RST;
			wide_capable_q <= smn_pkg::WIDE_CAPABLE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				smn_pkg::REG_MIN_PERIOD:   min_period_q   <= cfg_data;
				smn_pkg::REG_MAX_OFFSET:   max_offset_q   <= cfg_data;
				smn_pkg::REG_WIDE_CAPABLE: wide_capable_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// walk state
	smn_pkg::walk_state_t st_q, st_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] i_q, i_d;
	logic [7:0]    len_q, len_d;
	logic          ident_q, ident_d, rej_q, rej_d, dsync_q, dsync_d;
	logic          dwide_q, dwide_d, inc_q, inc_d, awide_q, awide_d;
	logic [7:0]    aper_q, aper_d, aoff_q, aoff_d;

	// memory and reply interfaces
	logic          ram_we;
	logic          rd_en;
	logic [2:0]    rd_off;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rdata;
	smn_pkg::reply_wr_t  rep_wr;
	smn_pkg::reply_ctl_t rep_ctl;
	logic          rep_avail;
	logic [7:0]    rep_byte;

	// result register
	logic          ovalid_q;
	logic [31:0]   odata_q;
	logic          out_load;
	logic          out_free;
	logic          in_acc;
	logic [31:0]   o_word;

	smn_pkg::kind_t kind;
	logic [SW-1:0] i_ext, cnt_ext, rd_sum, end_new, end_old;
	logic [7:0]    per_cl, off_cl;

	assign kind     = smn_pkg::kind_t'(s_tuser);
	assign out_free = !ovalid_q || m_tready;
	assign s_tready = (st_q == smn_pkg::S_IDLE) && out_free;
	assign in_acc   = s_tvalid && s_tready;
	assign m_tvalid = ovalid_q;
	assign m_tdata  = odata_q;

	assign i_ext   = SW'(i_q);
	assign cnt_ext = SW'(count_q);
	assign rd_sum  = i_ext + SW'(rd_off);
	assign rd_addr = rd_sum[AW-1:0];
	assign end_new = i_ext + SW'(2) + SW'(rdata);
	assign end_old = i_ext + SW'(2) + SW'(len_q);
	assign per_cl  = (rdata < min_period_q) ? min_period_q : rdata;
	assign off_cl  = (rdata > max_offset_q) ? max_offset_q : rdata;

	smn_msg_ram #(
		.DEPTH(MSG_DEPTH),
		.AW   (AW)
	) u_ram (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (count_q[AW-1:0]),
		.wdata  (s_tdata),
		.re     (rd_en),
		.raddr  (rd_addr),
		.rdata_q(rdata)
	);

	smn_reply u_reply (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (rep_wr),
		.ctl     (rep_ctl),
		.avail   (rep_avail),
		.byte_out(rep_byte)
	);

	always_comb begin
		st_d     = st_q;
		count_d  = count_q;
		i_d      = i_q;
		len_d    = len_q;
		ident_d  = ident_q;
		rej_d    = rej_q;
		dsync_d  = dsync_q;
		dwide_d  = dwide_q;
		inc_d    = inc_q;
		aper_d   = aper_q;
		aoff_d   = aoff_q;
		awide_d  = awide_q;
		ram_we   = 1'b0;
		rd_en    = 1'b0;
		rd_off   = 3'd0;
		rep_wr   = '0;
		rep_ctl  = '0;
		out_load = 1'b0;
		o_word   = 32'd0;
		case (st_q)
			smn_pkg::S_IDLE: begin
				if (in_acc) begin
					case (kind)
						smn_pkg::KIND_BYTE: begin
							out_load = 1'b1;
							if (count_q < CW'(MSG_DEPTH)) begin
								ram_we    = 1'b1;
								count_d   = count_q + CW'(1);
								o_word[0] = 1'b1;
							end
						end
						smn_pkg::KIND_READ: begin
							out_load    = 1'b1;
							rep_ctl.pop = rep_avail;
							o_word[0]   = rep_avail;
							o_word[8:1] = rep_byte;
						end
						smn_pkg::KIND_SESSION: begin
							out_load      = 1'b1;
							count_d       = '0;
							rep_ctl.clear = 1'b1;
						end
						smn_pkg::KIND_COMPLETE: begin
							i_d     = '0;
							ident_d = 1'b0;
							rej_d   = 1'b0;
							dsync_d = 1'b0;
							dwide_d = 1'b0;
							inc_d   = 1'b0;
							aper_d  = 8'd0;
							aoff_d  = 8'd0;
							awide_d = 1'b0;
							st_d    = smn_pkg::S_LEAD;
						end
						default: ;
					endcase
				end
			end
			smn_pkg::S_LEAD: begin
				if (i_ext >= cnt_ext) begin
					st_d = smn_pkg::S_DONE;
				end else begin
					rd_en = 1'b1;
					st_d  = smn_pkg::S_HEAD;
				end
			end
			smn_pkg::S_HEAD: begin
				if (rdata[smn_pkg::IDENT_BIT]) begin
					ident_d = 1'b1;
					i_d     = i_q + CW'(1);
					st_d    = smn_pkg::S_LEAD;
				end else if (rdata != smn_pkg::EXT_MSG) begin
					if (rdata == smn_pkg::REJECT_MSG) begin
						rej_d = 1'b1;
					end
					i_d  = i_q + CW'(1);
					st_d = smn_pkg::S_LEAD;
				end else if (i_ext + SW'(2) > cnt_ext) begin
					inc_d = 1'b1;
					st_d  = smn_pkg::S_DONE;
				end else begin
					rd_en  = 1'b1;
					rd_off = 3'd1;
					st_d   = smn_pkg::S_LEN;
				end
			end
			smn_pkg::S_LEN: begin
				len_d = rdata;
				if (end_new > cnt_ext) begin
					inc_d = 1'b1;
					st_d  = smn_pkg::S_DONE;
				end else if (rdata == 8'd0) begin
					// An empty extended message is refused and skipped.
					rep_wr.load = 1'b1;
					rep_wr.kind = smn_pkg::RK_REJECT;
					i_d         = end_new[CW-1:0];
					st_d        = smn_pkg::S_LEAD;
				end else begin
					rd_en  = 1'b1;
					rd_off = 3'd2;
					st_d   = smn_pkg::S_CODE;
				end
			end
			smn_pkg::S_CODE: begin
				if (rdata == smn_pkg::CODE_SYNC && len_q == smn_pkg::SYNC_LEN) begin
					rd_en  = 1'b1;
					rd_off = 3'd3;
					st_d   = smn_pkg::S_PER;
				end else if (rdata == smn_pkg::CODE_WIDE && len_q == smn_pkg::WIDE_LEN) begin
					rd_en  = 1'b1;
					rd_off = 3'd3;
					st_d   = smn_pkg::S_WIDTH;
				end else begin
					rep_wr.load = 1'b1;
					rep_wr.kind = smn_pkg::RK_REJECT;
					i_d         = end_old[CW-1:0];
					st_d        = smn_pkg::S_LEAD;
				end
			end
			smn_pkg::S_PER: begin
				aper_d = per_cl;
				rd_en  = 1'b1;
				rd_off = 3'd4;
				st_d   = smn_pkg::S_OFF;
			end
			smn_pkg::S_OFF: begin
				aoff_d      = off_cl;
				dsync_d     = 1'b1;
				rep_wr.load = 1'b1;
				rep_wr.kind = smn_pkg::RK_SYNC;
				rep_wr.per  = aper_q;
				rep_wr.off  = off_cl;
				i_d         = end_old[CW-1:0];
				st_d        = smn_pkg::S_LEAD;
			end
			smn_pkg::S_WIDTH: begin
				awide_d     = wide_capable_q && (rdata != 8'd0);
				dwide_d     = 1'b1;
				rep_wr.load = 1'b1;
				rep_wr.kind = smn_pkg::RK_WIDE;
				rep_wr.wide = wide_capable_q && (rdata != 8'd0);
				i_d         = end_old[CW-1:0];
				st_d        = smn_pkg::S_LEAD;
			end
			smn_pkg::S_DONE: begin
				if (out_free) begin
					out_load      = 1'b1;
					o_word[9]     = ident_q;
					o_word[10]    = rej_q;
					o_word[11]    = dsync_q;
					o_word[12]    = dwide_q;
					o_word[13]    = inc_q;
					o_word[21:14] = aper_q;
					o_word[29:22] = aoff_q;
					o_word[30]    = awide_q;
					// A truncated extended message leaves the buffer for more bytes.
					if (!inc_q) begin
						count_d = '0;
					end
					st_d = smn_pkg::S_IDLE;
				end
			end
			default: st_d = smn_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= smn_pkg::S_IDLE;
			count_q <= '0;
		end else begin
			st_q    <= st_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		i_q     <= i_d;
		len_q   <= len_d;
		ident_q <= ident_d;
		rej_q   <= rej_d;
		dsync_q <= dsync_d;
		dwide_q <= dwide_d;
		inc_q   <= inc_d;
		aper_q  <= aper_d;
		aoff_q  <= aoff_d;
		awide_q <= awide_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (out_load) begin
			ovalid_q <= 1'b1;
		end else if (m_tready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			odata_q <= o_word;
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MSG_DEPTH))
		else $error("buffer fill count above its depth");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (rd_sum < cnt_ext))
		else $error("walk reads a buffer entry that holds no byte");

	a_complete_starts_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && kind == smn_pkg::KIND_COMPLETE) |=> (st_q == smn_pkg::S_LEAD))
		else $error("complete word did not start the walk");

	a_done_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == smn_pkg::S_DONE && out_free && !inc_q) |=> (count_q == '0))
		else $error("finished walk left bytes in the buffer");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free)
		else $error("result register loaded over an untaken word");
`endif

endmodule
`default_nettype wire

>>> sv/smn_msg_ram.sv
// Message-out byte buffer: one write port and one registered read port.
`default_nettype none
module smn_msg_ram #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [7:0]    rdata_q
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

>>> sv/smn_reply.sv
// Reply queue: holds the last answer and pops it out one byte per read.
`default_nettype none
module smn_reply (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire smn_pkg::reply_wr_t  wr,
	input  wire smn_pkg::reply_ctl_t ctl,
	output logic                    avail,
	output logic [7:0]              byte_out
);

	smn_pkg::reply_kind_t kind_q;
	logic [2:0]           rptr_q;
	logic [7:0]           per_q;
	logic [7:0]           off_q;
	logic                 wide_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= smn_pkg::RK_NONE;
			rptr_q <= 3'd0;
		end else if (ctl.clear) begin
			kind_q <= smn_pkg::RK_NONE;
			rptr_q <= 3'd0;
		end else if (wr.load) begin
			kind_q <= wr.kind;
			rptr_q <= 3'd0;
		end else if (ctl.pop) begin
			rptr_q <= rptr_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.load) begin
			per_q  <= wr.per;
			off_q  <= wr.off;
			wide_q <= wr.wide;
		end
	end

	assign avail    = rptr_q < smn_pkg::reply_len(kind_q);
	assign byte_out = avail ? smn_pkg::reply_byte(kind_q, rptr_q, per_q, off_q, wide_q) : 8'h00;

endmodule
`default_nettype wire
